@@ rtl/core/bpra_pkg.sv @@
// Package for the bitmap page run allocator: sizes, codes and the word types.
// Used by bpra_ctrl and the top level; depends on nothing.
package bpra_pkg;

   localparam int NUM_PAGES = 4096;
   localparam int MAX_RUN   = 63;
   localparam int WORD_BITS = 64;
   localparam int MAP_WORDS = NUM_PAGES / WORD_BITS;
   localparam int ADDR_W    = $clog2(MAP_WORDS);
   localparam int PAGE_W    = 13;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WCNT_W    = PAGE_W - BIT_W;
   localparam int GRP_W     = 3;
   localparam int SUB_W     = BIT_W - GRP_W;
   localparam int GRP_BITS  = 1 << SUB_W;

   localparam logic [PAGE_W-1:0] PAGE_LIMIT = PAGE_W'(NUM_PAGES);
   localparam logic [PAGE_W-1:0] COUNT_MAX  = '1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] SEL_DMA      = 2'd0;
   localparam logic [1:0] SEL_NORMAL   = 2'd1;
   localparam logic [1:0] SEL_UNMAPPED = 2'd2;
   localparam logic [1:0] SEL_INVALID  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_COUNT = 2'd1;
   localparam logic [1:0] ST_BAD_REGION = 2'd2;
   localparam logic [1:0] ST_NO_SPACE  = 2'd3;

   localparam logic [1:0] CSR_LOW_FIRST  = 2'd0;
   localparam logic [1:0] CSR_LOW_END    = 2'd1;
   localparam logic [1:0] CSR_HIGH_FIRST = 2'd2;
   localparam logic [1:0] CSR_HIGH_END   = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [1:0]  region_select;
      logic [11:0] first_page;
      logic [5:0]  page_count;
   } bpra_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] alloc_page;
      logic        mapped_flag;
      logic [12:0] low_free_pages;
      logic [12:0] high_free_pages;
   } bpra_rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] low_first;
      logic [PAGE_W-1:0] low_end;
      logic [PAGE_W-1:0] high_first;
      logic [PAGE_W-1:0] high_end;
   } bpra_cfg_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_W-1:0]    addr;
      logic [WORD_BITS-1:0] wdata;
   } bpra_mem_type;

endpackage

@@ rtl/core/bpra_ram.sv @@
// Generic single-port RAM with a registered read.
// Stands alone; used for the page bitmap.
module bpra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/bpra_ctrl.sv @@
// Allocator sequencer: first-fit scan, bitmap set and clear, counts and result word.
// Depends on bpra_pkg; drives the bitmap RAM through a bpra_mem_type word.
module bpra_ctrl import bpra_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  bpra_cfg_type         cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bpra_req_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bpra_rsp_type         rsp_word,
   output bpra_mem_type         mem,
   input  logic [WORD_BITS-1:0] mem_rdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CHECK = 10'b0000000010,
      S_SRD   = 10'b0000000100,
      S_SLD   = 10'b0000001000,
      S_SCAN  = 10'b0000010000,
      S_MRD   = 10'b0000100000,
      S_MLD   = 10'b0001000000,
      S_MOP   = 10'b0010000000,
      S_MWR   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic [1:0]           sel_ff, sel_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [11:0]          fp_ff, fp_in;
   logic [WCNT_W-1:0]    word_ff, word_in;
   logic [GRP_W-1:0]     grp_ff, grp_in;
   logic [WORD_BITS-1:0] buf_ff, buf_in;
   logic [5:0]           run_ff, run_in;
   logic [PAGE_W-1:0]    start_ff, start_in;
   logic [PAGE_W-1:0]    first_ff, first_in;
   logic [PAGE_W-1:0]    end_ff, end_in;
   logic [PAGE_W-1:0]    lo_ff, lo_in;
   logic [PAGE_W-1:0]    hi_ff, hi_in;
   logic                 low_ff, low_in;
   logic [PAGE_W-1:0]    lcnt_ff, lcnt_in;
   logic [PAGE_W-1:0]    hcnt_ff, hcnt_in;
   logic [MAP_WORDS-1:0] valid_ff, valid_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bpra_rsp_type         rsp_word_ff, rsp_word_in;

   logic [PAGE_W-1:0] low_end_c, high_end_c;

   assign low_end_c  = (cfg.low_end > PAGE_LIMIT) ? PAGE_LIMIT : cfg.low_end;
   assign high_end_c = (cfg.high_end > PAGE_LIMIT) ? PAGE_LIMIT : cfg.high_end;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      logic [PAGE_W-1:0]    pg;
      logic [BIT_W-1:0]     idx;
      logic [5:0]           run_v;
      logic [PAGE_W-1:0]    start_v;
      logic                 found_v;
      logic [PAGE_W-1:0]    rfirst, rend, fc;
      logic [WCNT_W-1:0]    nw;
      logic [PAGE_W-1:0]    nw_page;
      logic [WORD_BITS-1:0] buf_v;
      logic [PAGE_W-1:0]    lc, hc;

      state_in     = state_ff;
      op_in        = op_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      fp_in        = fp_ff;
      word_in      = word_ff;
      grp_in       = grp_ff;
      buf_in       = buf_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      low_in       = low_ff;
      lcnt_in      = lcnt_ff;
      hcnt_in      = hcnt_ff;
      valid_in     = valid_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mem.we       = 1'b0;
      mem.addr     = word_ff[ADDR_W-1:0];
      mem.wdata    = buf_ff;

      pg      = '0;
      idx     = '0;
      run_v   = run_ff;
      start_v = start_ff;
      found_v = 1'b0;
      buf_v   = buf_ff;
      lc      = lcnt_ff;
      hc      = hcnt_ff;
      nw      = word_ff + WCNT_W'(1);
      nw_page = {nw, BIT_W'(0)};
      rfirst  = (sel_ff == SEL_UNMAPPED) ? cfg.high_first : cfg.low_first;
      rend    = (sel_ff == SEL_UNMAPPED) ? high_end_c : low_end_c;
      fc      = (sel_ff == SEL_UNMAPPED) ? hcnt_ff : lcnt_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_word.opcode;
               sel_in   = req_word.region_select;
               cnt_in   = req_word.page_count;
               fp_in    = req_word.first_page;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = ST_OK;
            if (cnt_ff == 6'd0 || 32'(cnt_ff) > MAX_RUN) begin
               status_in = ST_BAD_COUNT;
               state_in  = S_DONE;
            end else if (op_ff == OP_FREE) begin
               lo_in    = {1'b0, fp_ff};
               hi_in    = {1'b0, fp_ff} + PAGE_W'(cnt_ff);
               word_in  = {1'b0, fp_ff[11:BIT_W]};
               state_in = S_MRD;
            end else if (sel_ff == SEL_INVALID) begin
               status_in = ST_BAD_REGION;
               state_in  = S_DONE;
            end else if (fc < PAGE_W'(cnt_ff) || rfirst >= rend ||
                         (rend - rfirst) < PAGE_W'(cnt_ff)) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               low_in   = (sel_ff != SEL_UNMAPPED);
               first_in = rfirst;
               end_in   = rend;
               word_in  = rfirst[PAGE_W-1:BIT_W];
               run_in   = '0;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SLD;
         end
         S_SLD: begin
            buf_in   = valid_ff[word_ff[ADDR_W-1:0]] ? mem_rdata : '1;
            grp_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            for (int k = 0; k < GRP_BITS; k++) begin
               pg  = {word_ff, grp_ff, SUB_W'(k)};
               idx = {grp_ff, SUB_W'(k)};
               if (!found_v) begin
                  if (pg >= first_ff && pg < end_ff && !buf_ff[idx]) begin
                     if (run_v == 6'd0) begin
                        start_v = pg;
                     end
                     run_v = run_v + 6'd1;
                     if (run_v == cnt_ff) begin
                        found_v = 1'b1;
                     end
                  end else begin
                     run_v = '0;
                  end
               end
            end
            run_in   = run_v;
            start_in = start_v;
            if (found_v) begin
               lo_in    = start_v;
               hi_in    = start_v + PAGE_W'(cnt_ff);
               word_in  = start_v[PAGE_W-1:BIT_W];
               state_in = S_MRD;
            end else if (grp_ff == '1) begin
               if (nw_page >= end_ff) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_DONE;
               end else begin
                  word_in  = nw;
                  state_in = S_SRD;
               end
            end else begin
               grp_in = grp_ff + GRP_W'(1);
            end
         end
         S_MRD: begin
            state_in = S_MLD;
         end
         S_MLD: begin
            buf_in   = valid_ff[word_ff[ADDR_W-1:0]] ? mem_rdata : '1;
            grp_in   = '0;
            state_in = S_MOP;
         end
         S_MOP: begin
            for (int k = 0; k < GRP_BITS; k++) begin
               pg  = {word_ff, grp_ff, SUB_W'(k)};
               idx = {grp_ff, SUB_W'(k)};
               if (pg >= lo_ff && pg < hi_ff && pg < PAGE_LIMIT) begin
                  if (op_ff == OP_ALLOC) begin
                     buf_v[idx] = 1'b1;
                  end else if (buf_v[idx]) begin
                     buf_v[idx] = 1'b0;
                     if (pg >= cfg.low_first && pg < low_end_c) begin
                        lc = (lc == COUNT_MAX) ? lc : lc + PAGE_W'(1);
                     end else if (pg >= cfg.high_first && pg < high_end_c) begin
                        hc = (hc == COUNT_MAX) ? hc : hc + PAGE_W'(1);
                     end
                  end
               end
            end
            buf_in  = buf_v;
            lcnt_in = lc;
            hcnt_in = hc;
            if (grp_ff == '1) begin
               state_in = S_MWR;
            end else begin
               grp_in = grp_ff + GRP_W'(1);
            end
         end
         S_MWR: begin
            mem.we = 1'b1;
            valid_in[word_ff[ADDR_W-1:0]] = 1'b1;
            if (nw_page < hi_ff && 32'(nw) < MAP_WORDS) begin
               word_in  = nw;
               state_in = S_MRD;
            end else begin
               if (op_ff == OP_ALLOC) begin
                  if (low_ff) begin
                     lcnt_in = lcnt_ff - PAGE_W'(cnt_ff);
                  end else begin
                     hcnt_in = hcnt_ff - PAGE_W'(cnt_ff);
                  end
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.status          = status_ff;
               rsp_word_in.alloc_page      = '0;
               rsp_word_in.mapped_flag     = 1'b0;
               if (status_ff == ST_OK && op_ff == OP_ALLOC) begin
                  rsp_word_in.alloc_page  = lo_ff[11:0];
                  rsp_word_in.mapped_flag = low_ff;
               end
               rsp_word_in.low_free_pages  = lcnt_ff;
               rsp_word_in.high_free_pages = hcnt_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lcnt_ff      <= '0;
         hcnt_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcnt_ff      <= lcnt_in;
         hcnt_ff      <= hcnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sel_ff      <= sel_in;
      cnt_ff      <= cnt_in;
      fp_ff       <= fp_in;
      word_ff     <= word_in;
      grp_ff      <= grp_in;
      buf_ff      <= buf_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      first_ff    <= first_in;
      end_ff      <= end_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      low_ff      <= low_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

@@ rtl/core/bitmap_page_run_allocator.sv @@
// Top level of the bitmap page run allocator: region registers, bitmap RAM, sequencer.
// Depends on bpra_pkg, bpra_ram and bpra_ctrl.
//
//   channel   ports                                   direction
//   req       req_valid, req_stall, req_word          in  (opcode, region, page, count)
//   rsp       rsp_valid, rsp_stall, rsp_word          out (status, page, flag, counts)
//   csr       csr_valid, csr_ready, csr_index, csr_data   in  (region bounds)
//
// One word is handled at a time. An allocate reads each 64-page bitmap word it scans
// through the single RAM port and checks eight pages per cycle, then reads, updates and
// writes back each word it marks. A free reads, clears and writes back each word it covers.
// After reset every page reads as used without any clearing pass. A new word is
// taken while a finished result still waits behind rsp_stall.
module bitmap_page_run_allocator import bpra_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bpra_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output bpra_rsp_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_data
);

   bpra_cfg_type         cfg_ff, cfg_in;
   bpra_mem_type         mem;
   logic [WORD_BITS-1:0] mem_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOW_FIRST:  cfg_in.low_first  = csr_data;
            CSR_LOW_END:    cfg_in.low_end    = csr_data;
            CSR_HIGH_FIRST: cfg_in.high_first = csr_data;
            CSR_HIGH_END:   cfg_in.high_end   = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpra_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock(clock),
      .we   (mem.we),
      .addr (mem.addr),
      .wdata(mem.wdata),
      .rdata(mem_rdata)
   );

   bpra_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word),
      .mem      (mem),
      .mem_rdata(mem_rdata)
   );

endmodule
